### sv/status_frame_deframer_top_defines.svh
// Assertion macros shared by the status frame deframer modules.
`ifndef STATUS_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define STATUS_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SFD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sfd_pkg.sv
// Constants and the result type of the status frame deframer.
package sfd_pkg;

  localparam int unsigned POS_W = 5;
  localparam int unsigned STORE_DEPTH = 20;

  localparam logic [7:0] HDR0 = 8'hED;
  localparam logic [7:0] HDR1 = 8'hDE;
  localparam logic [7:0] HDR2 = 8'h1C;
  localparam logic [7:0] HDR4 = 8'h81;

  localparam logic [POS_W-1:0] POS_HDR1 = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HDR2 = POS_W'(2);
  localparam logic [POS_W-1:0] POS_HDR4 = POS_W'(4);
  localparam logic [POS_W-1:0] STORE_BASE = POS_W'(6);
  localparam logic [POS_W-1:0] SUM_BYTES = POS_W'(26);
  localparam logic [POS_W-1:0] FRAME_LEN = POS_W'(28);

  typedef struct packed {
    logic signed [15:0] speed_front_left;
    logic signed [15:0] speed_front_right;
    logic signed [15:0] speed_back_left;
    logic signed [15:0] speed_back_right;
    logic [15:0]        count_front_left;
    logic [15:0]        count_front_right;
    logic [15:0]        count_back_left;
    logic [15:0]        count_back_right;
    logic [15:0]        voltage_tenths;
    logic [15:0]        status_word;
    logic               checksum_ok;
  } sfd_result_t;

endpackage

### sv/sfd_byte_if.sv
// Request channel that carries one received serial byte.
interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### sv/sfd_frame_if.sv
// Request channel that carries one decoded status frame.
interface sfd_frame_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_front_left;
  logic signed [15:0] speed_front_right;
  logic signed [15:0] speed_back_left;
  logic signed [15:0] speed_back_right;
  logic [15:0]        count_front_left;
  logic [15:0]        count_front_right;
  logic [15:0]        count_back_left;
  logic [15:0]        count_back_right;
  logic [15:0]        voltage_tenths;
  logic [15:0]        status_word;
  logic               checksum_ok;

  modport source (
    output valid, input ready,
    output speed_front_left, output speed_front_right,
    output speed_back_left, output speed_back_right,
    output count_front_left, output count_front_right,
    output count_back_left, output count_back_right,
    output voltage_tenths, output status_word, output checksum_ok
  );
  modport sink (
    input valid, output ready,
    input speed_front_left, input speed_front_right,
    input speed_back_left, input speed_back_right,
    input count_front_left, input count_front_right,
    input count_back_left, input count_back_right,
    input voltage_tenths, input status_word, input checksum_ok
  );
endinterface

### sv/sfd_frame_parser.sv
// Byte input register, header hunt, running sum and payload shift store.
`include "status_frame_deframer_top_defines.svh"

module sfd_frame_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  output logic                in_ready,
  input  logic                hold,
  output logic                res_valid,
  output sfd_pkg::sfd_result_t res
);

  logic                     stage_valid;
  logic [7:0]               stage_byte;
  logic                     advance;

  logic [sfd_pkg::POS_W-1:0] position;
  logic [sfd_pkg::POS_W-1:0] position_next;
  logic [sfd_pkg::POS_W-1:0] pos_eff;
  logic [15:0]              running_sum;
  logic [15:0]              running_sum_next;
  logic [7:0]               checksum_low_byte;
  logic [7:0]               store [sfd_pkg::STORE_DEPTH];

  logic                     mismatch;
  logic                     store_shift;
  logic                     chk_load;
  logic                     frame_done;
  logic [sfd_pkg::POS_W-1:0] hunt_pos;
  logic [15:0]              hunt_sum;

  assign advance  = stage_valid && !hold;
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_byte <= in_byte;
    end
  end

  always_comb begin
    pos_eff = (position >= sfd_pkg::FRAME_LEN) ? '0 : position;
    hunt_pos = (stage_byte == sfd_pkg::HDR0) ? sfd_pkg::POS_W'(1) : '0;
    hunt_sum = (stage_byte == sfd_pkg::HDR0) ? {8'h00, sfd_pkg::HDR0} : 16'h0000;
    mismatch = (pos_eff == '0) ||
               ((pos_eff == sfd_pkg::POS_HDR1) && (stage_byte != sfd_pkg::HDR1)) ||
               ((pos_eff == sfd_pkg::POS_HDR2) && (stage_byte != sfd_pkg::HDR2)) ||
               ((pos_eff == sfd_pkg::POS_HDR4) && (stage_byte != sfd_pkg::HDR4));

    position_next    = position;
    running_sum_next = running_sum;
    store_shift      = 1'b0;
    chk_load         = 1'b0;
    frame_done       = 1'b0;

    priority if (mismatch) begin
      position_next    = hunt_pos;
      running_sum_next = hunt_sum;
    end else if (pos_eff < sfd_pkg::SUM_BYTES) begin
      running_sum_next = running_sum + {8'h00, stage_byte};
      store_shift      = (pos_eff >= sfd_pkg::STORE_BASE);
      position_next    = pos_eff + sfd_pkg::POS_W'(1);
    end else if (pos_eff == sfd_pkg::SUM_BYTES) begin
      chk_load      = 1'b1;
      position_next = pos_eff + sfd_pkg::POS_W'(1);
    end else begin
      frame_done       = 1'b1;
      position_next    = '0;
      running_sum_next = 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      running_sum <= 16'h0000;
    end else if (advance) begin
      position    <= position_next;
      running_sum <= running_sum_next;
    end
  end

  // The newest byte enters at the top, so after a frame entry 0 holds byte 6.
  always_ff @(posedge clk) begin
    if (advance && store_shift) begin
      for (int i = 0; i < sfd_pkg::STORE_DEPTH - 1; i++) begin
        store[i] <= store[i+1];
      end
      store[sfd_pkg::STORE_DEPTH-1] <= stage_byte;
    end
    if (advance && chk_load) begin
      checksum_low_byte <= stage_byte;
    end
  end

  assign res_valid = advance && frame_done;

  always_comb begin
    res.speed_front_left  = {store[1], store[0]};
    res.speed_front_right = {store[3], store[2]};
    res.speed_back_left   = {store[5], store[4]};
    res.speed_back_right  = {store[7], store[6]};
    res.count_front_left  = {store[9], store[8]};
    res.count_front_right = {store[11], store[10]};
    res.count_back_left   = {store[13], store[12]};
    res.count_back_right  = {store[15], store[14]};
    res.voltage_tenths    = {store[17], store[16]};
    res.status_word       = {store[19], store[18]};
    res.checksum_ok       = ({stage_byte, checksum_low_byte} == running_sum);
  end

  `SFD_ASSERT_IMP(a_pos_range, 1'b1, position < sfd_pkg::FRAME_LEN,
    "Byte position left the frame range.")
  `SFD_ASSERT_NXT(a_restart_after_frame, res_valid,
    (position == '0) && (running_sum == 16'h0000),
    "Hunt did not restart after a complete frame.")

endmodule

### sv/status_frame_deframer_top.sv
// Status frame deframer: serial bytes in, decoded 28-byte status frames out.
//
// The rx channel takes one received byte per request. The frame channel gives
// one request per complete frame whose header 0xED 0xDE 0x1C, any byte, 0x81
// was found, carrying the wheel speeds and counts, the voltage, the status
// word and a flag that is set when the 16-bit sum of bytes 0 to 25 matches the
// checksum word in bytes 26 and 27. Frames with a bad checksum are still sent.
// Throughput is one byte per cycle while the skid register is empty. The last
// byte of a frame passes through the byte input register before the frame is
// loaded into the frame output register, or into the skid register on a stall.
// Reset clears the hunt, the running sum and all valid flags; the block then
// hunts for a header again. When the receiver stalls, the waiting frame is
// held in the output register and a second frame can finish into a skid
// register; only with both full does rx stop taking bytes.
`include "status_frame_deframer_top_defines.svh"

module status_frame_deframer_top (
  input logic         clk,
  input logic         rst,
  sfd_byte_if.sink    rx,
  sfd_frame_if.source frame
);

  logic                 res_valid;
  sfd_pkg::sfd_result_t res;
  logic                 out_valid;
  sfd_pkg::sfd_result_t out_res;
  logic                 skid_valid;
  sfd_pkg::sfd_result_t skid_res;
  logic                 out_free;

  sfd_frame_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_byte   (rx.rx_byte),
    .in_ready  (rx.ready),
    .hold      (skid_valid),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free = !out_valid || frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (res_valid) begin
      skid_res <= res;
    end
  end

  assign frame.valid             = out_valid;
  assign frame.speed_front_left  = out_res.speed_front_left;
  assign frame.speed_front_right = out_res.speed_front_right;
  assign frame.speed_back_left   = out_res.speed_back_left;
  assign frame.speed_back_right  = out_res.speed_back_right;
  assign frame.count_front_left  = out_res.count_front_left;
  assign frame.count_front_right = out_res.count_front_right;
  assign frame.count_back_left   = out_res.count_back_left;
  assign frame.count_back_right  = out_res.count_back_right;
  assign frame.voltage_tenths    = out_res.voltage_tenths;
  assign frame.status_word       = out_res.status_word;
  assign frame.checksum_ok       = out_res.checksum_ok;

  `SFD_ASSERT_IMP(a_skid_needs_out, skid_valid, out_valid,
    "Skid register holds a frame while the output register is empty.")
  `SFD_ASSERT_NXT(a_skid_fill, res_valid && out_valid && !frame.ready, skid_valid,
    "Frame finished during a stall was not kept in the skid register.")
  `SFD_ASSERT_NXT(a_skid_drain, skid_valid && frame.ready, out_valid && !skid_valid,
    "Skid register did not move to the output register.")

endmodule
